// ----- design/edpu_pkg.sv -----
`timescale 1ns / 1ps

package edpu_pkg;

    // line store geometry
    localparam int MAX_WIDTH    = 1024;
    localparam int LINE_COUNT   = 4;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int PIX_W        = 8;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int SLOT_W       = $clog2(LINE_COUNT);
    localparam int WORD_W       = PIX_W * LINE_COUNT;
    localparam int SUB_COUNT    = 9;
    localparam int OUT_W        = PIX_W * SUB_COUNT;

    // register field widths
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int ZOOM_REG_W   = 2;
    localparam int CFG_DATA_W   = 13;

    typedef logic [PIX_W-1:0]  pix_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [OUT_W-1:0]  block_t;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_ZOOM_FACTOR   = 2'd2,
        REG_SMOOTH_ENABLE = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } cmd_t;

    localparam logic [ZOOM_REG_W-1:0] ZOOM_3X = 2'd3;

    // line store access issued with an accepted beat
    typedef struct packed {
        logic  we;
        col_t  waddr;
        slot_t wslot;
        pix_t  wdata;
        logic  re;
        col_t  raddr_a;
        col_t  raddr_b;
    } mem_req_t;

    // beat waiting for its line store read data
    typedef struct packed {
        logic  valid;
        logic  shift;
        logic  emit;
        logic  line_start;
        logic  line_end;
        logic  fwd_a;
        logic  fwd_b;
        slot_t wslot;
        pix_t  pix;
        logic  use_pix;
        slot_t slot_m2;
        slot_t slot_m1;
        slot_t slot_c;
        slot_t slot_p1;
        slot_t slot_p2;
        logic  last;
        logic  zoom3;
        logic  smooth;
    } stage_t;

    typedef struct packed {
        pix_t a, b, c, d, e, f, g, h, i, j, k, l, m;
    } nbr_t;

    function automatic pix_t lane(word_t w, slot_t s);
        return w[PIX_W*s +: PIX_W];
    endfunction

    function automatic word_t put_lane(word_t w, slot_t s, pix_t p);
        word_t r;
        r = w;
        r[PIX_W*s +: PIX_W] = p;
        return r;
    endfunction

    // edge rules for one centre, packed sub0 in the lowest byte
    function automatic block_t sfx_block(nbr_t n, logic smooth, logic zoom3);
        pix_t   ev [SUB_COUNT];
        logic   c0, c1, c2, c3;
        block_t r;
        for (int k = 0; k < SUB_COUNT; k++) begin
            ev[k] = n.e;
        end
        c0 = n.e != n.a || n.e == n.c || n.e == n.g || n.a == n.j || n.a == n.k;
        c1 = n.e != n.c || n.e == n.a || n.e == n.i || n.c == n.j || n.c == n.l;
        c2 = n.e != n.g || n.e == n.a || n.e == n.i || n.g == n.k || n.g == n.m;
        c3 = n.e != n.i || n.e == n.c || n.e == n.g || n.i == n.l || n.i == n.m;
        if (smooth && n.b != n.h && n.d != n.f) begin
            if (n.d == n.b && c0) ev[0] = n.d;
            if (n.b == n.f && c1) ev[1] = n.f;
            if (n.d == n.h && c2) ev[2] = n.d;
            if (n.h == n.f && c3) ev[3] = n.f;
            if ((n.d == n.b && n.e != n.c && c0) || (n.b == n.f && n.e != n.a && c1))
                ev[5] = n.b;
            if ((n.d == n.b && n.e != n.g && c0) || (n.d == n.h && n.e != n.a && c2))
                ev[6] = n.d;
            if ((n.b == n.f && n.e != n.i && c3 && n.e != n.c) ||
                (n.h == n.f && n.e != n.c && c1 && n.e != n.i))
                ev[7] = n.f;
            if ((n.d == n.h && n.e != n.i && c3 && n.e != n.g) ||
                (n.h == n.f && n.e != n.g && c2 && n.e != n.i))
                ev[8] = n.h;
        end
        if (zoom3) begin
            r = {ev[3], ev[8], ev[2], ev[7], ev[4], ev[6], ev[1], ev[5], ev[0]};
        end else begin
            r = {{(5*PIX_W){1'b0}}, ev[3], ev[2], ev[1], ev[0]};
        end
        return r;
    endfunction

endpackage

// ----- design/edpu_line_store.sv -----
`timescale 1ns / 1ps

module edpu_line_store (
    input  logic             aclk,
    input  edpu_pkg::mem_req_t req,
    output edpu_pkg::word_t  rdata_a,
    output edpu_pkg::word_t  rdata_b
);

    // one word per column, one byte lane per line slot
    edpu_pkg::word_t mem [edpu_pkg::MAX_WIDTH];
    edpu_pkg::word_t rdata_a_reg;
    edpu_pkg::word_t rdata_b_reg;

    // byte-lane write, read returns the old word
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr][edpu_pkg::PIX_W*req.wslot +: edpu_pkg::PIX_W] <= req.wdata;
        end
        if (req.re) begin
            rdata_a_reg <= mem[req.raddr_a];
            rdata_b_reg <= mem[req.raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- design/edpu_ctrl.sv -----
`timescale 1ns / 1ps

module edpu_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [edpu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic                              advance,
    output edpu_pkg::stage_t                  stage,
    output edpu_pkg::mem_req_t                mem_req
);

    localparam int CW = edpu_pkg::COL_W;
    localparam int RW = edpu_pkg::ROW_W;

    logic [edpu_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [edpu_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [edpu_pkg::ZOOM_REG_W-1:0]   zoom_reg;
    logic                              smooth_reg;

    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic          draining_reg, draining_next;
    edpu_pkg::stage_t stage_reg, stage_next;

    logic [edpu_pkg::WIDTH_REG_W-1:0]  wdec;
    logic [edpu_pkg::HEIGHT_REG_W-1:0] hdec;
    logic [CW-1:0] wm1, col, cx, x, addr_a, addr_b;
    logic [RW-1:0] hm1, row, cy, y;
    logic [CW:0]   x2;
    logic [RW:0]   y1, y2;
    logic          accept, is_drain, pix_go, drn_go, line_end, last_c;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd320;
            height_reg <= 13'd200;
            zoom_reg   <= 2'd2;
            smooth_reg <= 1'b1;
        end else if (cfg_valid) begin
            case (edpu_pkg::cfg_index_t'(cfg_index))
                edpu_pkg::REG_IMAGE_WIDTH:   width_reg  <= cfg_data[edpu_pkg::WIDTH_REG_W-1:0];
                edpu_pkg::REG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                edpu_pkg::REG_ZOOM_FACTOR:   zoom_reg   <= cfg_data[edpu_pkg::ZOOM_REG_W-1:0];
                edpu_pkg::REG_SMOOTH_ENABLE: smooth_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamped image size, as last index
    always_comb begin
        wdec = width_reg - 1'b1;
        hdec = height_reg - 1'b1;
        if (width_reg == '0)
            wm1 = '0;
        else if (width_reg > edpu_pkg::WIDTH_REG_W'(edpu_pkg::MAX_WIDTH))
            wm1 = CW'(edpu_pkg::MAX_WIDTH - 1);
        else
            wm1 = wdec[CW-1:0];
        if (height_reg == '0)
            hm1 = '0;
        else if (height_reg > edpu_pkg::HEIGHT_REG_W'(edpu_pkg::HEIGHT_LIMIT))
            hm1 = RW'(edpu_pkg::HEIGHT_LIMIT - 1);
        else
            hm1 = hdec[RW-1:0];
    end

    assign s_axis_tready = !stage_reg.valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_drain      = edpu_pkg::cmd_t'(s_axis_tuser) == edpu_pkg::CMD_DRAIN;
    assign pix_go        = !is_drain && !draining_reg;
    assign drn_go        = is_drain && draining_reg;

    // centre position, read addresses and line slots
    always_comb begin
        col = (in_col_reg > wm1) ? wm1 : in_col_reg;
        row = (in_row_reg > hm1) ? hm1 : in_row_reg;
        cx  = (out_col_reg > wm1) ? wm1 : out_col_reg;
        cy  = (out_row_reg > hm1) ? hm1 : out_row_reg;
        x   = pix_go ? col : cx;
        y   = pix_go ? row - RW'(2) : cy;
        line_end = x == wm1;
        last_c   = drn_go && cx == wm1 && cy == hm1;
        x2 = {1'b0, x} + (CW+1)'(2);
        if (line_end)
            addr_a = '0;
        else if (x2 > {1'b0, wm1})
            addr_a = wm1;
        else
            addr_a = x2[CW-1:0];
        addr_b = (wm1 == '0) ? '0 : CW'(1);
        y1 = {1'b0, y} + (RW+1)'(1);
        y2 = {1'b0, y} + (RW+1)'(2);

        stage_next            = '0;
        stage_next.valid      = s_axis_tvalid;
        stage_next.shift      = pix_go || drn_go;
        stage_next.emit       = (pix_go && row >= RW'(2)) || drn_go;
        stage_next.line_start = x == '0;
        stage_next.line_end   = line_end;
        stage_next.fwd_a      = pix_go && line_end && col == '0;
        stage_next.fwd_b      = pix_go && line_end && col == addr_b;
        stage_next.wslot      = row[edpu_pkg::SLOT_W-1:0];
        stage_next.pix        = s_axis_tdata;
        stage_next.use_pix    = pix_go;
        stage_next.slot_m2    = (y < RW'(2)) ? '0 :
                                y[edpu_pkg::SLOT_W-1:0] - edpu_pkg::SLOT_W'(2);
        stage_next.slot_m1    = (y == '0) ? '0 :
                                y[edpu_pkg::SLOT_W-1:0] - edpu_pkg::SLOT_W'(1);
        stage_next.slot_c     = y[edpu_pkg::SLOT_W-1:0];
        stage_next.slot_p1    = (y1 > {1'b0, hm1}) ? hm1[edpu_pkg::SLOT_W-1:0] :
                                y1[edpu_pkg::SLOT_W-1:0];
        stage_next.slot_p2    = (y2 > {1'b0, hm1}) ? hm1[edpu_pkg::SLOT_W-1:0] :
                                y2[edpu_pkg::SLOT_W-1:0];
        stage_next.last       = last_c;
        stage_next.zoom3      = zoom_reg == edpu_pkg::ZOOM_3X;
        stage_next.smooth     = smooth_reg;

        mem_req.we      = accept && pix_go;
        mem_req.waddr   = col;
        mem_req.wslot   = row[edpu_pkg::SLOT_W-1:0];
        mem_req.wdata   = s_axis_tdata;
        mem_req.re      = accept;
        mem_req.raddr_a = addr_a;
        mem_req.raddr_b = addr_b;
    end

    // raster counters
    always_comb begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        draining_next = draining_reg;
        if (accept && pix_go) begin
            if (row >= RW'(2)) begin
                if (col == wm1) begin
                    out_col_next = '0;
                    out_row_next = row - RW'(1);
                end else begin
                    out_col_next = col + CW'(1);
                    out_row_next = row - RW'(2);
                end
            end
            if (col == wm1) begin
                in_col_next = '0;
                if (row == hm1) begin
                    in_row_next   = '0;
                    draining_next = 1'b1;
                end else begin
                    in_row_next = row + RW'(1);
                end
            end else begin
                in_col_next = col + CW'(1);
                in_row_next = row;
            end
        end else if (accept && drn_go) begin
            if (last_c) begin
                out_col_next  = '0;
                out_row_next  = '0;
                draining_next = 1'b0;
            end else if (cx == wm1) begin
                out_col_next = '0;
                out_row_next = cy + RW'(1);
            end else begin
                out_col_next = cx + CW'(1);
                out_row_next = cy;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            draining_reg <= 1'b0;
            stage_reg    <= '0;
        end else begin
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            draining_reg <= draining_next;
            if (s_axis_tready) begin
                stage_reg <= stage_next;
            end
        end
    end

    assign stage = stage_reg;

endmodule

// ----- design/edpu_kernel.sv -----
`timescale 1ns / 1ps

module edpu_kernel (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  edpu_pkg::stage_t         stage,
    input  edpu_pkg::word_t          rdata_a,
    input  edpu_pkg::word_t          rdata_b,
    output logic                     advance,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [edpu_pkg::OUT_W-1:0] m_axis_tdata,
    output logic                     m_axis_tlast
);

    edpu_pkg::word_t win_reg [5];
    edpu_pkg::word_t win_next [5];
    edpu_pkg::word_t pf0_reg, pf1_reg, pf0_next, pf1_next;
    edpu_pkg::nbr_t  nbr;
    edpu_pkg::block_t block;
    edpu_pkg::block_t data_reg;
    logic            valid_reg, last_reg, move;

    assign advance = !valid_reg || m_axis_tready;
    assign move    = stage.valid && advance && stage.shift;

    // column window x-2..x+2, at line start x-2..x+1 come from the prefetched columns
    always_comb begin
        if (stage.line_start) begin
            win_next[0] = pf0_reg;
            win_next[1] = pf0_reg;
            win_next[2] = pf0_reg;
            win_next[3] = pf1_reg;
            win_next[4] = stage.line_end ? pf1_reg : rdata_a;
        end else begin
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = win_reg[4];
            win_next[4] = stage.line_end ? win_reg[4] : rdata_a;
        end
        pf0_next = stage.fwd_a ? edpu_pkg::put_lane(rdata_a, stage.wslot, stage.pix) : rdata_a;
        pf1_next = stage.fwd_b ? edpu_pkg::put_lane(rdata_b, stage.wslot, stage.pix) : rdata_b;
    end

    // neighbourhood pick and edge rules
    always_comb begin
        nbr.j = edpu_pkg::lane(win_next[2], stage.slot_m2);
        nbr.a = edpu_pkg::lane(win_next[1], stage.slot_m1);
        nbr.b = edpu_pkg::lane(win_next[2], stage.slot_m1);
        nbr.c = edpu_pkg::lane(win_next[3], stage.slot_m1);
        nbr.k = edpu_pkg::lane(win_next[0], stage.slot_c);
        nbr.d = edpu_pkg::lane(win_next[1], stage.slot_c);
        nbr.e = edpu_pkg::lane(win_next[2], stage.slot_c);
        nbr.f = edpu_pkg::lane(win_next[3], stage.slot_c);
        nbr.l = edpu_pkg::lane(win_next[4], stage.slot_c);
        nbr.g = edpu_pkg::lane(win_next[1], stage.slot_p1);
        nbr.h = edpu_pkg::lane(win_next[2], stage.slot_p1);
        nbr.i = edpu_pkg::lane(win_next[3], stage.slot_p1);
        nbr.m = stage.use_pix ? stage.pix : edpu_pkg::lane(win_next[2], stage.slot_p2);
        block = edpu_pkg::sfx_block(nbr, stage.smooth, stage.zoom3);
    end

    // window and prefetch registers
    always_ff @(posedge aclk) begin
        if (move) begin
            for (int k = 0; k < 5; k++) begin
                win_reg[k] <= win_next[k];
            end
            if (stage.line_end) begin
                pf0_reg <= pf0_next;
                pf1_reg <= pf1_next;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage.valid && stage.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= block;
            last_reg <= stage.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

// ----- design/edge_directed_pixel_upscaler.sv -----
`timescale 1ns / 1ps
// channel   dir  signals                    contents
// s_axis    in   tvalid tready tdata tuser  tdata: pixel_value; tuser: command
// m_axis    out  tvalid tready tdata tlast  tdata: sub0..sub8; tlast: frame_last
// cfg       in   cfg_valid cfg_ready        cfg_index, cfg_data
//
// one beat per cycle unless m_axis stalls; a block is registered after the read stage.
// each beat reads two line store words and each pixel beat writes one byte, which
// sets the rate; line starts use two columns prefetched at the previous line end.
// reset clears counters and valids and sets config defaults; no line store clearing pass.
// with m_axis_tready low one more beat is taken into the read stage, then input stalls.

module edge_directed_pixel_upscaler (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [edpu_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] pixel_value
    input  logic                              s_axis_tuser,  // [0] command
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [edpu_pkg::OUT_W-1:0]        m_axis_tdata,  // sub0 [7:0] .. sub8 [71:64]
    output logic                              m_axis_tlast   // frame_last
);

    edpu_pkg::stage_t   stage;
    edpu_pkg::mem_req_t mem_req;
    edpu_pkg::word_t    rdata_a, rdata_b;
    logic               advance;

    edpu_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .advance       (advance),
        .stage         (stage),
        .mem_req       (mem_req)
    );

    edpu_line_store u_line_store (
        .aclk    (aclk),
        .req     (mem_req),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    edpu_kernel u_kernel (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .stage         (stage),
        .rdata_a       (rdata_a),
        .rdata_b       (rdata_b),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 600000;

    logic               aclk;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = edpu_pkg::REG_IMAGE_WIDTH;
    logic [edpu_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;   // [7:0] pixel_value
    logic               s_axis_tuser = edpu_pkg::CMD_PIXEL;  // [0] command
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [edpu_pkg::OUT_W-1:0] m_axis_tdata;  // sub0 [7:0] .. sub8 [71:64]
    logic               m_axis_tlast;        // frame_last

    edge_directed_pixel_upscaler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // shadow of the upscaler state
    logic [7:0]  shadow_lines [0:edpu_pkg::LINE_COUNT*edpu_pkg::MAX_WIDTH-1];
    int          sh_width, sh_height;
    logic [1:0]  sh_zoom;
    logic        sh_smooth;
    int          in_col, in_row, out_col, out_row;
    bit          flushing;

    // expected blocks, {frame_last, sub8..sub0}
    logic [edpu_pkg::OUT_W:0] block_q [$];

    int fail_count;
    int blocks_seen;
    int items_sent;
    int frames_done;
    int idle_pct;
    int stall_pct;
    int hold_cycles;
    int cycle_count;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int eff_width();
        int v;
        v = sh_width;
        if (v < 1) v = 1;
        if (v > edpu_pkg::MAX_WIDTH) v = edpu_pkg::MAX_WIDTH;
        return v;
    endfunction

    function automatic int eff_height();
        int v;
        v = sh_height;
        if (v < 1) v = 1;
        if (v > edpu_pkg::HEIGHT_LIMIT) v = edpu_pkg::HEIGHT_LIMIT;
        return v;
    endfunction

    function automatic logic [7:0] px_at(int x, int y);
        int w;
        int hh;
        w = eff_width();
        hh = eff_height();
        if (x < 0) x = 0;
        if (x > w - 1) x = w - 1;
        if (y < 0) y = 0;
        if (y > hh - 1) y = hh - 1;
        return shadow_lines[(y % edpu_pkg::LINE_COUNT) * edpu_pkg::MAX_WIDTH + x];
    endfunction

    // sfx edge rules on the 13-pixel neighborhood of (x, y)
    function automatic logic [edpu_pkg::OUT_W:0] upscale_block(int x, int y,
                                                              logic [7:0] nj, bit last);
        logic [7:0] na, nb, nc, nd, ne, nf, ng, nh, ni, nk, nl, nm;
        logic [7:0] ev [9];
        bit c0, c1, c2, c3;
        logic [edpu_pkg::OUT_W-1:0] blk;
        na = px_at(x - 1, y - 1); nb = px_at(x, y - 1); nc = px_at(x + 1, y - 1);
        nd = px_at(x - 1, y);     ne = px_at(x, y);     nf = px_at(x + 1, y);
        ng = px_at(x - 1, y + 1); nh = px_at(x, y + 1); ni = px_at(x + 1, y + 1);
        nk = px_at(x - 2, y);     nl = px_at(x + 2, y); nm = px_at(x, y + 2);
        for (int k = 0; k < 9; k++) ev[k] = ne;
        if (sh_smooth && nb != nh && nd != nf) begin
            c0 = ne != na || ne == nc || ne == ng || na == nj || na == nk;
            c1 = ne != nc || ne == na || ne == ni || nc == nj || nc == nl;
            c2 = ne != ng || ne == na || ne == ni || ng == nk || ng == nm;
            c3 = ne != ni || ne == nc || ne == ng || ni == nl || ni == nm;
            if (nd == nb && c0) ev[0] = nd;
            if (nb == nf && c1) ev[1] = nf;
            if (nd == nh && c2) ev[2] = nd;
            if (nh == nf && c3) ev[3] = nf;
            if ((nd == nb && ne != nc && c0) || (nb == nf && ne != na && c1)) ev[5] = nb;
            if ((nd == nb && ne != ng && c0) || (nd == nh && ne != na && c2)) ev[6] = nd;
            if ((nb == nf && ne != ni && c3 && ne != nc) ||
                (nh == nf && ne != nc && c1 && ne != ni)) ev[7] = nf;
            if ((nd == nh && ne != ni && c3 && ne != ng) ||
                (nh == nf && ne != ng && c2 && ne != ni)) ev[8] = nh;
        end
        if (sh_zoom == edpu_pkg::ZOOM_3X)
            blk = {ev[3], ev[8], ev[2], ev[7], ev[4], ev[6], ev[1], ev[5], ev[0]};
        else
            blk = {40'd0, ev[3], ev[2], ev[1], ev[0]};
        return {last, blk};
    endfunction

    // advance the shadow by one accepted beat
    function automatic void advance_upscaler(logic cmd, logic [7:0] pix);
        int w, hh, col, row, cx, cy;
        logic [7:0] jv;
        bit last;
        w = eff_width();
        hh = eff_height();
        if (cmd == edpu_pkg::CMD_PIXEL) begin
            if (flushing) return;
            col = (in_col > w - 1) ? w - 1 : in_col;
            row = (in_row > hh - 1) ? hh - 1 : in_row;
            jv = 8'd0;
            if (row >= 2) jv = px_at(col, row - 4);
            shadow_lines[(row % edpu_pkg::LINE_COUNT) * edpu_pkg::MAX_WIDTH + col] = pix;
            if (row >= 2) begin
                block_q.push_back(upscale_block(col, row - 2, jv, 1'b0));
                if (col + 1 >= w) begin out_col = 0; out_row = row - 1; end
                else begin out_col = col + 1; out_row = row - 2; end
            end
            if (col + 1 >= w) begin
                in_col = 0;
                if (row + 1 >= hh) begin in_row = 0; flushing = 1'b1; end
                else in_row = row + 1;
            end else begin
                in_col = col + 1;
                in_row = row;
            end
        end else begin
            if (!flushing) return;
            cx = (out_col > w - 1) ? w - 1 : out_col;
            cy = (out_row > hh - 1) ? hh - 1 : out_row;
            last = (cx == w - 1) && (cy == hh - 1);
            block_q.push_back(upscale_block(cx, cy, px_at(cx, cy - 2), last));
            if (last) begin
                out_col = 0; out_row = 0; flushing = 1'b0;
            end else if (cx + 1 >= w) begin
                out_col = 0; out_row = cy + 1;
            end else begin
                out_col = cx + 1; out_row = cy;
            end
        end
    endfunction

    // one beat on the input stream, ends on a falling edge
    task automatic send_item(logic cmd, logic [7:0] pix);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        advance_upscaler(cmd, pix);
        items_sent++;
        @(negedge aclk);
    endtask

    // drop valid and wait for every block plus the pipeline tail
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        wait (block_q.size() == 0);
        repeat (4) @(negedge aclk);
    endtask

    // one register write, valid is left high for a following write
    task automatic write_reg(edpu_pkg::cfg_index_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[edpu_pkg::CFG_DATA_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            edpu_pkg::REG_IMAGE_WIDTH:   sh_width  = val & 'h7FF;
            edpu_pkg::REG_IMAGE_HEIGHT:  sh_height = val & 'h1FFF;
            edpu_pkg::REG_ZOOM_FACTOR:   sh_zoom   = val[1:0];
            edpu_pkg::REG_SMOOTH_ENABLE: sh_smooth = val[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic setup_image(int w, int hh, int zoom, int smooth);
        settle();
        write_reg(edpu_pkg::REG_IMAGE_WIDTH, w);
        write_reg(edpu_pkg::REG_IMAGE_HEIGHT, hh);
        write_reg(edpu_pkg::REG_ZOOM_FACTOR, zoom);
        write_reg(edpu_pkg::REG_SMOOTH_ENABLE, smooth);
        cfg_valid <= 1'b0;
    endtask

    // whole frame of pixels, mostly from three colors, then drains to the last block
    task automatic send_frame(bit noisy);
        logic [7:0] colors [3];
        int total;
        total = eff_width() * eff_height();
        for (int k = 0; k < 3; k++) colors[k] = $urandom_range(255);
        if (noisy && $urandom_range(1)) send_item(edpu_pkg::CMD_DRAIN, $urandom_range(255));
        for (int p = 0; p < total; p++) begin
            if ($urandom_range(9) == 0) send_item(edpu_pkg::CMD_PIXEL, $urandom_range(255));
            else send_item(edpu_pkg::CMD_PIXEL, colors[$urandom_range(2)]);
        end
        while (flushing) begin
            if (noisy && $urandom_range(7) == 0)
                send_item(edpu_pkg::CMD_PIXEL, $urandom_range(255));
            else
                send_item(edpu_pkg::CMD_DRAIN, $urandom_range(255));
        end
        frames_done++;
    endtask

    // hand-built 4x4 frame with edges, saturated values and the ignored beats, then a 3x2 and a 1x1 frame
    task automatic test_directed();
        logic [7:0] img [16];
        img = '{8'd10, 8'd10, 8'd20, 8'd20,
                8'd10, 8'd20, 8'd20, 8'd30,
                8'd0, 8'd255, 8'd255, 8'd0,
                8'd255, 8'd0, 8'd0, 8'd255};
        setup_image(4, 4, 3, 1);
        send_item(edpu_pkg::CMD_DRAIN, 8'd0);           // drain while idle is ignored
        for (int p = 0; p < 16; p++) send_item(edpu_pkg::CMD_PIXEL, img[p]);
        send_item(edpu_pkg::CMD_DRAIN, 8'd255);
        send_item(edpu_pkg::CMD_PIXEL, 8'd77);          // pixel during flush is dropped
        while (flushing) send_item(edpu_pkg::CMD_DRAIN, 8'd0);
        frames_done++;
        // short frame, nothing comes out before the drains
        setup_image(3, 2, 0, 0);
        send_frame(1'b0);
        setup_image(1, 1, 1, 1);
        send_frame(1'b0);
    endtask

    task automatic test_random_frames();
        int modes_idle [4] = '{0, 73, 0, 30};
        int modes_stall [4] = '{0, 0, 73, 30};
        int start;
        for (int m = 0; m < 4; m++) begin
            idle_pct  = modes_idle[m];
            stall_pct = modes_stall[m];
            start = items_sent;
            while (items_sent - start < 50) begin
                setup_image(($urandom_range(3) == 0) ? $urandom_range(1, 30)
                                                     : $urandom_range(1, 8),
                            $urandom_range(1, 8), $urandom_range(3),
                            ($urandom_range(4) != 0));
                send_frame(1'b1);
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    // zero size registers clamp up to one
    task automatic test_extremes();
        setup_image(0, 3, 3, 1);
        send_frame(1'b0);
        setup_image(5, 0, 2, 1);
        send_frame(1'b0);
    endtask

    // long receiver hold-off while the sender keeps pushing
    task automatic test_backpressure();
        setup_image(8, 6, 3, 1);
        hold_cycles = 300;
        send_frame(1'b0);
        setup_image(8, 6, 2, 1);
        hold_cycles = 300;
        idle_pct = 30;
        send_frame(1'b1);
        idle_pct = 0;
    endtask

    // receiver ready, random stalls or a counted hold-off
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each block with the oldest expectation
    always @(posedge aclk) begin
        logic [edpu_pkg::OUT_W:0] exp_blk;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (block_q.size() == 0) begin
                $error("unexpected block %h", m_axis_tdata);
                fail_count++;
            end else begin
                exp_blk = block_q.pop_front();
                blocks_seen++;
                for (int k = 0; k < edpu_pkg::SUB_COUNT; k++) begin
                    if (exp_blk[8*k +: 8] !== m_axis_tdata[8*k +: 8]) begin
                        $error("sub%0d expected %0d actual %0d", k,
                               exp_blk[8*k +: 8], m_axis_tdata[8*k +: 8]);
                        fail_count++;
                    end
                end
                if (exp_blk[edpu_pkg::OUT_W] !== m_axis_tlast) begin
                    $error("frame_last expected %0d actual %0d",
                           exp_blk[edpu_pkg::OUT_W], m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < edpu_pkg::LINE_COUNT * edpu_pkg::MAX_WIDTH; k++)
            shadow_lines[k] = 8'd0;
        sh_width = 320; sh_height = 200; sh_zoom = 2'd2; sh_smooth = 1'b1;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0; flushing = 1'b0;
        fail_count = 0; blocks_seen = 0; items_sent = 0; frames_done = 0;
        idle_pct = 0; stall_pct = 0; hold_cycles = 0; cycle_count = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_random_frames();
        test_extremes();
        test_backpressure();
        settle();
        repeat (10) @(negedge aclk);
        $display("covered %0d frames, %0d beats, %0d blocks checked", frames_done,
                 items_sent, blocks_seen);
        $display("both zooms, smoothing on/off, clamped sizes, idle mixes, long stall");
        if (fail_count == 0 && block_q.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
